[src/rdip_pkg.sv]
// ----------------------------------------------------------------------------
// rdip_pkg
// shared types and constants for the rrip replacement unit with dip set dueling
// ----------------------------------------------------------------------------
`default_nettype none

package rdip_pkg;

    // geometry (NUM_SETS is a power of two, set index reduced by its low bits)
    localparam int NUM_SETS     = 2048;
    localparam int NUM_WAYS     = 16;
    localparam int LEADER_COUNT = 64;
    localparam int HALF_SETS    = NUM_SETS / 2;

    localparam int SET_W   = $clog2(NUM_SETS);
    localparam int ROW_W   = 2 * NUM_WAYS;
    localparam int WAY_W   = 4;
    localparam int WAYCT_W = WAY_W + 1;
    localparam int RR_W    = 2;
    localparam int SEL_W   = 10;

    localparam logic [SEL_W-1:0] SEL_RESET  = 10'd512;
    localparam logic [SEL_W-1:0] SEL_MAX    = 10'd1023;
    localparam logic [RR_W-1:0]  RR_DISTANT = 2'd3;
    localparam logic [RR_W-1:0]  RR_NEAR    = 2'd2;

    // item kinds
    localparam logic [1:0] KIND_VICTIM = 2'd0;
    localparam logic [1:0] KIND_HIT    = 2'd1;
    localparam logic [1:0] KIND_FILL   = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] set_index;
        logic [3:0]  way_index;
        logic [15:0] valid_mask;
        logic [4:0]  random_draw;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  victim_way;
        logic [9:0]  selector_now;
    } t_out_item;

    // control from the sequencer to the way scan unit
    typedef struct packed {
        logic clear;
        logic step;
    } t_scan_ctl;

    // results of the way scan
    typedef struct packed {
        logic             inv_found;
        logic [WAY_W-1:0] inv_way;
        logic [RR_W-1:0]  max_rr;
        logic [WAY_W-1:0] max_way;
    } t_scan_res;

endpackage

`default_nettype wire

[src/rdip_ram.sv]
// ----------------------------------------------------------------------------
// rdip_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rdip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/rdip_way_unit.sv]
// ----------------------------------------------------------------------------
// rdip_way_unit
// shared compare unit, looks at one way per step: tracks the lowest invalid
// way and the lowest way holding the largest re-reference value
// ----------------------------------------------------------------------------
`default_nettype none

module rdip_way_unit (
    input  wire logic                           i_clk,
    input  wire rdip_pkg::t_scan_ctl            i_ctl,
    input  wire logic [rdip_pkg::WAY_W-1:0]     i_way,
    input  wire logic [rdip_pkg::RR_W-1:0]      i_rr,
    input  wire logic                           i_valid_bit,
    output rdip_pkg::t_scan_res                 o_res
);

    rdip_pkg::t_scan_res r_res;

    // one way per step, strictly greater keeps the lowest way of the maximum
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_res.inv_found <= 1'b0;
            r_res.inv_way   <= '0;
            r_res.max_rr    <= '0;
            r_res.max_way   <= '0;
        end else if (i_ctl.step) begin
            if (!r_res.inv_found && !i_valid_bit) begin
                r_res.inv_found <= 1'b1;
                r_res.inv_way   <= i_way;
            end
            if (i_rr > r_res.max_rr) begin
                r_res.max_rr  <= i_rr;
                r_res.max_way <= i_way;
            end
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

[src/rrip_dip_cache_replacement_unit.sv]
// ----------------------------------------------------------------------------
// rrip_dip_cache_replacement_unit
// rrip replacement state with dip set dueling between lip and bip insertion
// ----------------------------------------------------------------------------
// flow: hit and fill transactions go through the read, write and done states,
//   victim requests add a scan state (one way per cycle through the scan unit)
//   between read and write; one item in flight, input stalled until the done
//   state loads the output register; the ram write port is shared by the
//   clearing pass and the item write back. reset: a clearing pass writes
//   every set row to zero with input stalled; policy selector resets to 512
`default_nettype none

module rrip_dip_cache_replacement_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire rdip_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output rdip_pkg::t_out_item       o_out_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } t_state;

    t_state                          r_state;
    logic [rdip_pkg::SET_W-1:0]      r_clr_idx;
    rdip_pkg::t_in_item              r_item;
    logic [rdip_pkg::SET_W-1:0]      r_set;
    logic [rdip_pkg::ROW_W-1:0]      r_row;
    logic [rdip_pkg::WAY_W-1:0]      r_way;
    logic [rdip_pkg::SEL_W-1:0]      r_sel;
    rdip_pkg::t_out_item             r_res;
    logic                            r_out_valid;
    rdip_pkg::t_out_item             r_out_data;

    logic [rdip_pkg::ROW_W-1:0]      n_row;
    logic                            n_we;
    logic [rdip_pkg::WAY_W-1:0]      n_victim;
    logic [rdip_pkg::SEL_W-1:0]      n_sel;

    logic                            in_accept;
    logic                            out_free;
    logic [rdip_pkg::SET_W-1:0]      in_set;
    logic [rdip_pkg::RR_W-1:0]       age;
    logic [rdip_pkg::RR_W-1:0]       depth;
    logic [rdip_pkg::RR_W-1:0]       bip_depth;
    logic                            way_ok;
    logic                            lip_leader;
    logic                            bip_leader;
    logic [rdip_pkg::SET_W-1:0]      bip_off;

    logic                            ram_we;
    logic [rdip_pkg::SET_W-1:0]      ram_waddr;
    logic [rdip_pkg::ROW_W-1:0]      ram_wdata;
    logic [rdip_pkg::ROW_W-1:0]      ram_rdata;

    rdip_pkg::t_scan_ctl             scan_ctl;
    rdip_pkg::t_scan_res             scan_res;

    // handshakes
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // set index reduced to the set count
    assign in_set = i_in_data.set_index[rdip_pkg::SET_W-1:0];

    // set row store
    rdip_ram #(
        .WIDTH (rdip_pkg::ROW_W),
        .DEPTH (rdip_pkg::NUM_SETS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (in_set),
        .o_rdata (ram_rdata)
    );

    // write port: clearing pass or item write back
    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_idx;
            ram_wdata = '0;
        end else begin
            ram_we    = (r_state == ST_WRITE) && n_we;
            ram_waddr = r_set;
            ram_wdata = n_row;
        end
    end

    // shared way scan unit
    assign scan_ctl.clear = in_accept;
    assign scan_ctl.step  = (r_state == ST_SCAN);

    rdip_way_unit u_scan (
        .i_clk       (i_clk),
        .i_ctl       (scan_ctl),
        .i_way       (r_way),
        .i_rr        (r_row[{r_way, 1'b0} +: rdip_pkg::RR_W]),
        .i_valid_bit (r_item.valid_mask[r_way]),
        .o_res       (scan_res)
    );

    // leader set decode
    assign bip_off    = r_set - rdip_pkg::SET_W'(rdip_pkg::HALF_SETS);
    assign lip_leader = (r_set < rdip_pkg::SET_W'(rdip_pkg::LEADER_COUNT));
    assign bip_leader = (r_set >= rdip_pkg::SET_W'(rdip_pkg::HALF_SETS))
                     && (bip_off < rdip_pkg::SET_W'(rdip_pkg::LEADER_COUNT));
    assign way_ok     = ({1'b0, r_item.way_index}
                         < rdip_pkg::WAYCT_W'(rdip_pkg::NUM_WAYS));

    // insertion depth for fills
    assign bip_depth = (r_item.random_draw == '0) ? rdip_pkg::RR_NEAR
                                                  : rdip_pkg::RR_DISTANT;
    always_comb begin
        if (lip_leader) begin
            depth = rdip_pkg::RR_DISTANT;
        end else if (bip_leader) begin
            depth = bip_depth;
        end else if (r_sel >= rdip_pkg::SEL_RESET) begin
            depth = rdip_pkg::RR_DISTANT;
        end else begin
            depth = bip_depth;
        end
    end

    assign age = rdip_pkg::RR_DISTANT - scan_res.max_rr;

    // row update, victim and selector for the item in hand
    always_comb begin
        n_row    = r_row;
        n_we     = 1'b0;
        n_victim = '0;
        n_sel    = r_sel;
        case (r_item.kind)
            rdip_pkg::KIND_VICTIM: begin
                if (scan_res.inv_found) begin
                    n_victim = scan_res.inv_way;
                end else begin
                    n_victim = scan_res.max_way;
                    n_we     = (age != '0);
                    for (int w = 0; w < rdip_pkg::NUM_WAYS; w++) begin
                        n_row[2*w +: rdip_pkg::RR_W] = r_row[2*w +: rdip_pkg::RR_W] + age;
                    end
                end
            end
            rdip_pkg::KIND_HIT: begin
                if (way_ok) begin
                    n_we = 1'b1;
                    n_row[{r_item.way_index, 1'b0} +: rdip_pkg::RR_W] = '0;
                    if (lip_leader && (r_sel != '0)) begin
                        n_sel = r_sel - 1'b1;
                    end
                    if (bip_leader && (r_sel != rdip_pkg::SEL_MAX)) begin
                        n_sel = r_sel + 1'b1;
                    end
                end
            end
            rdip_pkg::KIND_FILL: begin
                if (way_ok) begin
                    n_we = 1'b1;
                    n_row[{r_item.way_index, 1'b0} +: rdip_pkg::RR_W] = depth;
                end
            end
            default: begin
                n_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_sel       <= rdip_pkg::SEL_RESET;
            r_out_valid <= 1'b0;
            r_way       <= '0;
        end else begin
            // the done state loads the output register itself
            if (r_out_valid && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == rdip_pkg::SET_W'(rdip_pkg::NUM_SETS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        r_item  <= i_in_data;
                        r_set   <= in_set;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_row <= ram_rdata;
                    r_way <= '0;
                    if (r_item.kind == rdip_pkg::KIND_VICTIM) begin
                        r_state <= ST_SCAN;
                    end else begin
                        r_state <= ST_WRITE;
                    end
                end
                ST_SCAN: begin
                    r_way <= r_way + 1'b1;
                    if (r_way == rdip_pkg::WAY_W'(rdip_pkg::NUM_WAYS - 1)) begin
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    r_sel              <= n_sel;
                    r_res.victim_way   <= n_victim;
                    r_res.selector_now <= n_sel;
                    r_state            <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[tb/rdip_replacement_checker.sv]
// ----------------------------------------------------------------------------
// rdip_replacement_checker
// watches both channels of the rrip/dip replacement unit, predicts every
// reply from its own copy of the set rows and the policy selector, and
// compares each accepted reply field by field with the oldest prediction
// ----------------------------------------------------------------------------
module rdip_replacement_checker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire rdip_pkg::t_in_item   i_in_data,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire rdip_pkg::t_out_item  i_out_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rdip_pkg::*;

    // predicted state of the block
    logic [ROW_W-1:0] rr_rows [NUM_SETS];
    logic [SEL_W-1:0] psel;

    // replies predicted but not yet seen on the output channel
    t_out_item predicted_replies [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // one line per mismatch
    task automatic report_mismatch(input string what, input int want, input int got);
        o_fail_count++;
        $display("mismatch: %s expected %0d got %0d at %0t", what, want, got, $realtime);
    endtask

    // leader set classification
    function automatic bit lip_leader(input int s);
        return s < LEADER_COUNT;
    endfunction

    function automatic bit bip_leader(input int s);
        return s >= HALF_SETS && (s - HALF_SETS) < LEADER_COUNT;
    endfunction

    // apply one transaction to the predicted state and form its reply
    task automatic predict_replacement(input t_in_item item, output t_out_item reply);
        int               s;
        int               way;
        logic [ROW_W-1:0] row;
        logic [RR_W-1:0]  maxv;
        logic [RR_W-1:0]  age;
        logic [RR_W-1:0]  depth;
        logic [WAY_W-1:0] victim;
        bit               found;
        s      = int'(item.set_index) % NUM_SETS;
        way    = int'(item.way_index);
        row    = rr_rows[s];
        victim = '0;
        found  = 1'b0;
        case (item.kind)
            KIND_VICTIM: begin
                // lowest invalid way wins without touching the set
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (!found && !item.valid_mask[w]) begin
                        victim = WAY_W'(w);
                        found  = 1'b1;
                    end
                end
                if (!found) begin
                    // age the whole set until the oldest way is distant
                    maxv = '0;
                    for (int w = 0; w < NUM_WAYS; w++) begin
                        if (row[2*w +: 2] > maxv) maxv = row[2*w +: 2];
                    end
                    age = RR_DISTANT - maxv;
                    for (int w = 0; w < NUM_WAYS; w++) begin
                        row[2*w +: 2] = row[2*w +: 2] + age;
                    end
                    rr_rows[s] = row;
                    for (int w = 0; w < NUM_WAYS; w++) begin
                        if (!found && row[2*w +: 2] == RR_DISTANT) begin
                            victim = WAY_W'(w);
                            found  = 1'b1;
                        end
                    end
                end
            end
            KIND_HIT: begin
                if (way < NUM_WAYS) begin
                    row[2*way +: 2] = '0;
                    rr_rows[s]      = row;
                    // leader hits train the selector, saturating
                    if (lip_leader(s) && psel != '0) psel = psel - 1'b1;
                    if (bip_leader(s) && psel != SEL_MAX) psel = psel + 1'b1;
                end
            end
            KIND_FILL: begin
                if (way < NUM_WAYS) begin
                    if (lip_leader(s)) begin
                        depth = RR_DISTANT;
                    end else if (bip_leader(s) || psel < SEL_RESET) begin
                        depth = (item.random_draw == '0) ? RR_NEAR : RR_DISTANT;
                    end else begin
                        depth = RR_DISTANT;
                    end
                    row[2*way +: 2] = depth;
                    rr_rows[s]      = row;
                end
            end
            default: ;
        endcase
        reply.victim_way   = victim;
        reply.selector_now = psel;
    endtask

    // sample both channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SETS; s++) rr_rows[s] = '0;
            psel = SEL_RESET;
            predicted_replies.delete();
        end else begin
            // a reply leaving now belongs to an earlier transaction
            if (i_out_valid && !i_out_stall) begin
                if (predicted_replies.size() == 0) begin
                    report_mismatch("reply with nothing pending, victim_way", -1,
                                    int'(i_out_data.victim_way));
                end else begin
                    want = predicted_replies.pop_front();
                    if (i_out_data.victim_way !== want.victim_way) begin
                        report_mismatch("victim_way", int'(want.victim_way),
                                        int'(i_out_data.victim_way));
                    end
                    if (i_out_data.selector_now !== want.selector_now) begin
                        report_mismatch("selector_now", int'(want.selector_now),
                                        int'(i_out_data.selector_now));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_replacement(i_in_data, want);
                predicted_replies = {predicted_replies, want};
            end
        end
        o_pending <= predicted_replies.size();
    end

endmodule

[tb/rrip_dip_cache_replacement_unit_tb.sv]
// ----------------------------------------------------------------------------
// rrip_dip_cache_replacement_unit_tb
// drives victim, hit and fill transactions into the replacement unit under
// several idle and stall mixes, trains the policy selector down to its lower
// limit and back up, and reports the verdict from the checker's failure count
// ----------------------------------------------------------------------------
module rrip_dip_cache_replacement_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rdip_pkg::*;

    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         DRAIN_CYCLES = 2 * NUM_WAYS + 8;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    // selector training direction of a phase
    localparam int PUSH_NONE = 0;
    localparam int PUSH_DOWN = 1;
    localparam int PUSH_UP   = 2;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_stall = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    int fail_count;
    int pending;
    int cycles       = 0;
    int in_idle_pct  = 0;
    int out_stall_pct = 0;

    // sets revisited often so that aging and training interact
    logic [10:0] lip_hot    [4];
    logic [10:0] bip_hot    [4];
    logic [10:0] follow_hot [6];

    rrip_dip_cache_replacement_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    rdip_replacement_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // offer one transaction and hold it until accepted
    task automatic send_item(input t_in_item item);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic send_fields(input logic [1:0] kind, input logic [10:0] set_index,
                               input logic [3:0] way_index, input logic [15:0] valid_mask,
                               input logic [4:0] random_draw);
        t_in_item item;
        item.kind        = kind;
        item.set_index   = set_index;
        item.way_index   = way_index;
        item.valid_mask  = valid_mask;
        item.random_draw = random_draw;
        send_item(item);
    endtask

    // random transaction, optionally biased to train the selector
    function automatic t_in_item make_item(input int push);
        t_in_item item;
        int       r;
        r = $urandom_range(99);
        if (push != PUSH_NONE && r < 92) begin
            item.kind      = KIND_HIT;
            item.set_index = (push == PUSH_DOWN) ? lip_hot[$urandom_range(3)]
                                                 : bip_hot[$urandom_range(3)];
        end else begin
            r = $urandom_range(99);
            if (r < 35)      item.kind = KIND_VICTIM;
            else if (r < 60) item.kind = KIND_HIT;
            else if (r < 95) item.kind = KIND_FILL;
            else             item.kind = KIND_UNUSED;
            r = $urandom_range(99);
            if (r < 25)      item.set_index = lip_hot[$urandom_range(3)];
            else if (r < 50) item.set_index = bip_hot[$urandom_range(3)];
            else if (r < 85) item.set_index = follow_hot[$urandom_range(5)];
            else             item.set_index = 11'($urandom_range(2047));
        end
        item.way_index = 4'($urandom_range(15));
        r = $urandom_range(99);
        if (r < 55)      item.valid_mask = '1;
        else if (r < 75) item.valid_mask = ~(16'd1 << $urandom_range(15));
        else             item.valid_mask = 16'($urandom_range(65535));
        item.random_draw = ($urandom_range(99) < 30) ? 5'd0 : 5'($urandom_range(31));
        return item;
    endfunction

    task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                             input int push);
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        repeat (count) send_item(make_item(push));
    endtask

    // stimulus
    initial begin
        lip_hot    = '{11'd0, 11'd63, 11'($urandom_range(63)), 11'($urandom_range(63))};
        bip_hot    = '{11'd1024, 11'd1087, 11'(1024 + $urandom_range(63)),
                       11'(1024 + $urandom_range(63))};
        follow_hot = '{11'd1023, 11'd1088, 11'd2047, 11'd64,
                       11'(64 + $urandom_range(959)), 11'(1088 + $urandom_range(959))};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: invalid ways, aging, leader training and insertion depths
        send_fields(KIND_VICTIM, 11'd5,    4'd0,  16'hFFFF, 5'd0);
        send_fields(KIND_VICTIM, 11'd5,    4'd0,  16'h0000, 5'd0);
        send_fields(KIND_VICTIM, 11'd5,    4'd0,  16'h7FFF, 5'd0);
        send_fields(KIND_VICTIM, 11'd5,    4'd0,  16'hFFEF, 5'd0);
        send_fields(KIND_HIT,    11'd5,    4'd0,  16'h0000, 5'd0);
        send_fields(KIND_VICTIM, 11'd5,    4'd0,  16'hFFFF, 5'd0);
        send_fields(KIND_HIT,    11'd0,    4'd15, 16'h0000, 5'd0);
        send_fields(KIND_HIT,    11'd63,   4'd3,  16'h0000, 5'd0);
        send_fields(KIND_FILL,   11'd100,  4'd2,  16'h0000, 5'd0);
        send_fields(KIND_FILL,   11'd100,  4'd7,  16'h0000, 5'd31);
        send_fields(KIND_HIT,    11'd1024, 4'd0,  16'h0000, 5'd0);
        send_fields(KIND_HIT,    11'd1087, 4'd1,  16'h0000, 5'd0);
        send_fields(KIND_HIT,    11'd1088, 4'd2,  16'h0000, 5'd0);
        send_fields(KIND_HIT,    11'd64,   4'd2,  16'h0000, 5'd0);
        send_fields(KIND_FILL,   11'd100,  4'd2,  16'h0000, 5'd0);
        send_fields(KIND_FILL,   11'd0,    4'd5,  16'h0000, 5'd0);
        send_fields(KIND_FILL,   11'd1024, 4'd5,  16'h0000, 5'd0);
        send_fields(KIND_FILL,   11'd1087, 4'd6,  16'h0000, 5'd17);
        send_fields(KIND_HIT,    11'd2047, 4'd15, 16'hFFFF, 5'd31);
        send_fields(KIND_FILL,   11'd2047, 4'd15, 16'hFFFF, 5'd0);
        send_fields(KIND_VICTIM, 11'd1024, 4'd0,  16'hFFFF, 5'd0);
        send_fields(KIND_UNUSED, 11'd2047, 4'd15, 16'h0000, 5'd31);
        send_fields(KIND_VICTIM, 11'd2047, 4'd15, 16'hFFFF, 5'd31);

        // random phases, selector driven to zero and then back up
        run_phase(30,  0,  0,  PUSH_NONE);
        run_phase(600, 0,  0,  PUSH_DOWN);
        run_phase(40,  73, 0,  PUSH_NONE);
        run_phase(30,  0,  73, PUSH_UP);
        run_phase(30,  34, 34, PUSH_NONE);

        @(negedge i_clk);
        in_valid      <= 1'b0;
        out_stall_pct  = 0;

        // drain
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
